// ===== rtl/cpkfd_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types
// for the command-port key FIFO device. No dependencies.
package cpkfd_pkg;

  localparam int RING_DEPTH  = 16;
  localparam int WINDOW_SIZE = 16;

  localparam int DATA_W    = 8;
  localparam int PORT_W    = 4;
  localparam int REQ_W     = 2;
  localparam int OUT_CNT_W = 5;

  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int WIN_AW  = $clog2(WINDOW_SIZE);
  localparam int TAIL_W  = RING_AW + 2;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_KEY   = 2'd2;

  localparam logic [DATA_W-1:0] CMD_RESET     = 8'h00;
  localparam logic [DATA_W-1:0] CMD_CLASS     = 8'h01;
  localparam logic [DATA_W-1:0] CMD_VENDOR    = 8'h02;
  localparam logic [DATA_W-1:0] CMD_PRODUCT   = 8'h03;
  localparam logic [DATA_W-1:0] CMD_NAME      = 8'h04;
  localparam logic [DATA_W-1:0] CMD_COUNT     = 8'h10;
  localparam logic [DATA_W-1:0] CMD_READ_ONE  = 8'h11;
  localparam logic [DATA_W-1:0] CMD_READ_MANY = 8'h12;
  localparam logic [DATA_W-1:0] CMD_CLEAR     = 8'h13;

  localparam logic [DATA_W-1:0] VID_BYTES  [4] = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
  localparam logic [DATA_W-1:0] PID_BYTES  [4] = '{"K", "B", "D", 8'h00};
  localparam logic [DATA_W-1:0] NAME_BYTES [7] = '{"S", "T", "D", "K", "B", "D", 8'h00};

  // APB register map
  localparam int                CFG_AW      = 3;
  localparam int                CFG_DW      = 32;
  localparam logic [0:0]        REG_CLASS   = 1'b0;
  localparam logic [DATA_W-1:0] CLASS_RESET = 8'h01;

  typedef struct packed {
    logic accept;
    logic exec;
    logic pop;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic read_many;
    logic pop_more;
  } dp_stat_t;

endpackage

// ===== rtl/cpkfd_ctrl.sv =====
// Sequencer for the key FIFO device: item intake, execute, read-many loop
// and output register hand-off. Depends on cpkfd_pkg.
module cpkfd_ctrl import cpkfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_WAIT,
    ST_POP,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.exec     = (state_r == ST_EXEC);
    cmd.pop      = (state_r == ST_POP);
    cmd.load_out = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:     state_nxt = stat.read_many ? ST_POP_WAIT : ST_FINISH;
      ST_POP_WAIT: state_nxt = stat.pop_more ? ST_POP : ST_FINISH;
      ST_POP:      state_nxt = ST_POP_WAIT;
      ST_FINISH:   if (cmd.load_out) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/cpkfd_dp.sv =====
// Datapath: register window, key ring memory with head/count, command
// execution and the output register. Depends on cpkfd_pkg.
module cpkfd_dp import cpkfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [DATA_W-1:0]    class_code,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [PORT_W-1:0]    in_port,
  input  logic [DATA_W-1:0]    in_wdata,
  input  logic [DATA_W-1:0]    in_key_byte,
  output logic [DATA_W-1:0]    out_rdata,
  output logic [OUT_CNT_W-1:0] out_buffered_count,
  output logic                 out_key_dropped
);

  logic [REQ_W-1:0]     req_r;
  logic [PORT_W-1:0]    port_r;
  logic [DATA_W-1:0]    wdata_r;
  logic [DATA_W-1:0]    key_r;

  logic [DATA_W-1:0]    win_r [WINDOW_SIZE];
  logic [DATA_W-1:0]    ring_mem [RING_DEPTH];
  logic [DATA_W-1:0]    ring_rd_r;
  logic [RING_AW-1:0]   head_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     idx_r;

  logic [DATA_W-1:0]    res_rdata_r;
  logic                 res_drop_r;
  logic [DATA_W-1:0]    out_rdata_r;
  logic [OUT_CNT_W-1:0] out_count_r;
  logic                 out_drop_r;

  logic                 port_in_win;
  logic [WIN_AW-1:0]    port_idx;
  logic                 is_write;
  logic                 is_cmd;
  logic                 ring_full;
  logic                 key_push;
  logic [TAIL_W-1:0]    tail_sum;
  logic [RING_AW-1:0]   tail;
  logic [RING_AW-1:0]   head_inc;
  logic [DATA_W-1:0]    count_sat;
  logic [CNT_W-1:0]     r1_sat;
  logic [CNT_W-1:0]     n_cnt;
  logic [CNT_W-1:0]     n_nxt;

  assign port_in_win = 32'(port_r) < WINDOW_SIZE;
  assign port_idx    = WIN_AW'(port_r);
  assign is_write    = (req_r == REQ_WRITE) && port_in_win;
  assign is_cmd      = is_write && (port_r == '0);
  assign ring_full   = 32'(count_r) >= RING_DEPTH;
  assign key_push    = cmd.exec && (req_r == REQ_KEY) && !ring_full;

  assign tail_sum = TAIL_W'(head_r) + TAIL_W'(count_r);
  assign tail     = (tail_sum >= TAIL_W'(RING_DEPTH)) ?
                    RING_AW'(tail_sum - TAIL_W'(RING_DEPTH)) : RING_AW'(tail_sum);
  assign head_inc = (head_r == RING_AW'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign count_sat = (32'(count_r) > 255) ? 8'hFF : 8'(count_r);

  // n = min(reg1, count, window)
  assign r1_sat = (32'(win_r[1]) > RING_DEPTH) ? CNT_W'(RING_DEPTH) : CNT_W'(win_r[1]);
  assign n_cnt  = (r1_sat < count_r) ? r1_sat : count_r;
  assign n_nxt  = (32'(n_cnt) > WINDOW_SIZE) ? CNT_W'(WINDOW_SIZE) : n_cnt;

  assign stat.read_many = is_cmd && (wdata_r == CMD_READ_MANY);
  assign stat.pop_more  = (idx_r != n_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_req_type;
      port_r  <= in_port;
      wdata_r <= in_wdata;
      key_r   <= in_key_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (key_push) begin
      ring_mem[tail] <= key_r;
    end
    ring_rd_r <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_r[i] <= '0;
      end
      head_r  <= '0;
      count_r <= '0;
      n_r     <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.exec) begin
        if (key_push) begin
          count_r <= count_r + 1'b1;
        end
        if (is_write) begin
          win_r[port_idx] <= wdata_r;
        end
        if (is_cmd) begin
          unique case (wdata_r)
            CMD_RESET: begin
              count_r <= '0;
              for (int i = 0; i < WINDOW_SIZE; i++) begin
                win_r[i] <= '0;
              end
            end
            CMD_CLASS: win_r[0] <= class_code;
            CMD_VENDOR: begin
              for (int i = 0; i < 4; i++) begin
                win_r[i] <= VID_BYTES[i];
              end
            end
            CMD_PRODUCT: begin
              for (int i = 0; i < 4; i++) begin
                win_r[i] <= PID_BYTES[i];
              end
            end
            CMD_NAME: begin
              for (int i = 0; i < 7; i++) begin
                win_r[i] <= NAME_BYTES[i];
              end
            end
            CMD_COUNT: win_r[0] <= count_sat;
            CMD_READ_ONE: begin
              if (count_r == '0) begin
                win_r[0] <= '0;
              end else begin
                win_r[0] <= ring_rd_r;
                head_r   <= head_inc;
                count_r  <= count_r - 1'b1;
              end
            end
            CMD_READ_MANY: begin
              n_r   <= n_nxt;
              idx_r <= '0;
            end
            CMD_CLEAR: count_r <= '0;
            default: ;
          endcase
        end
      end
      if (cmd.pop) begin
        win_r[WIN_AW'(idx_r)] <= ring_rd_r;
        head_r  <= head_inc;
        count_r <= count_r - 1'b1;
        idx_r   <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_rdata_r <= ((req_r == REQ_READ) && port_in_win) ? win_r[port_idx] : '0;
      res_drop_r  <= (req_r == REQ_KEY) && ring_full;
    end
    if (cmd.load_out) begin
      out_rdata_r <= res_rdata_r;
      out_count_r <= OUT_CNT_W'(count_r);
      out_drop_r  <= res_drop_r;
    end
  end

  assign out_rdata          = out_rdata_r;
  assign out_buffered_count = out_count_r;
  assign out_key_dropped    = out_drop_r;

endmodule

// ===== rtl/command_port_key_fifo_device_unit.sv =====
// Top level of the command-port key FIFO device: APB class register,
// controller and datapath. Depends on cpkfd_pkg, cpkfd_ctrl, cpkfd_dp.
//
//   channel   ports                                      direction
//   in        in_valid/in_stall + req_type,port,wdata,key in
//   out       out_valid/out_stall + rdata,count,dropped  out
//   cfg       psel,penable,pwrite,paddr,pwdata,prdata    APB slave
//
// Bus write, bus read and key items run through the execute and finish
// states; finish loads the output register. Read-many pops each key via
// pop-wait and pop: the key ring has one registered read port.
// Synchronous active-low reset clears the window, ring head and count.
// A stalled result sits in the output register while the next item runs.
module command_port_key_fifo_device_unit import cpkfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [PORT_W-1:0]    in_port,
  input  logic [DATA_W-1:0]    in_wdata,
  input  logic [DATA_W-1:0]    in_key_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_rdata,
  output logic [OUT_CNT_W-1:0] out_buffered_count,
  output logic                 out_key_dropped,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [DATA_W-1:0] class_code_r;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_AW-1:2] == REG_CLASS);
  assign prdata  = reg_sel ? CFG_DW'(class_code_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_code_r <= CLASS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      class_code_r <= pwdata[DATA_W-1:0];
    end
  end

  cpkfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpkfd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .class_code         (class_code_r),
    .in_req_type        (in_req_type),
    .in_port            (in_port),
    .in_wdata           (in_wdata),
    .in_key_byte        (in_key_byte),
    .out_rdata          (out_rdata),
    .out_buffered_count (out_buffered_count),
    .out_key_dropped    (out_key_dropped)
  );

endmodule
